@@ rtl/rgbhsv_pkg.sv @@
// Shared types and constants for the RGB to HSV converter.
// Used by rgbhsv_front, rgbhsv_queue, rgbhsv_back and the top level.
// No dependencies.
package rgbhsv_pkg;

    // Channel and result widths
    localparam int CH_W      = 8;
    localparam int HUE_W     = 16;
    // Hue numerator and 6*delta both stay below 2048
    localparam int NUM_W     = 11;
    // One quotient bit per divider stage
    localparam int SAT_STEPS = 8;
    localparam int HUE_STEPS = 16;

    // Which channel holds the maximum (ties: red, then green, then blue)
    typedef enum logic [2:0] {
        SEL_RED   = 3'b001,
        SEL_GREEN = 3'b010,
        SEL_BLUE  = 3'b100
    } t_max_sel;

    // Classified pixel, handed from the front through the queue to the back
    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] vmax;
        logic [CH_W-1:0] delta;
        t_max_sel        sel;
    } t_cls;

    // Queue status seen by the front
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

@@ rtl/rgbhsv_front.sv @@
// Front end of the RGB to HSV converter: accepts a pixel, finds max, min,
// delta and the winning channel, and pushes the classified pixel to the queue.
// Depends on rgbhsv_pkg.
module rgbhsv_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [rgbhsv_pkg::CH_W-1:0] i_red,
    input  logic [rgbhsv_pkg::CH_W-1:0] i_green,
    input  logic [rgbhsv_pkg::CH_W-1:0] i_blue,
    input  rgbhsv_pkg::t_q_stat        i_q_stat,
    output logic                       o_busy,
    output logic                       o_push,
    output rgbhsv_pkg::t_cls           o_item
);

    logic                        r_valid;
    logic                        n_valid;
    rgbhsv_pkg::t_cls            r_item;
    rgbhsv_pkg::t_cls            n_item;
    logic                        w_accept;
    logic [rgbhsv_pkg::CH_W-1:0] w_min_rg;
    logic [rgbhsv_pkg::CH_W-1:0] w_min;

    // Hold the staged pixel while the queue is full
    assign o_push   = r_valid && !i_q_stat.full;
    assign o_busy   = r_valid && i_q_stat.full;
    assign w_accept = i_start && !o_busy;
    assign o_item   = r_item;

    // Classify: pick the maximum with red over green over blue on ties
    always_comb begin
        n_item       = r_item;
        n_item.red   = i_red;
        n_item.green = i_green;
        n_item.blue  = i_blue;
        if (i_red >= i_green && i_red >= i_blue) begin
            n_item.sel  = rgbhsv_pkg::SEL_RED;
            n_item.vmax = i_red;
        end else if (i_green >= i_blue) begin
            n_item.sel  = rgbhsv_pkg::SEL_GREEN;
            n_item.vmax = i_green;
        end else begin
            n_item.sel  = rgbhsv_pkg::SEL_BLUE;
            n_item.vmax = i_blue;
        end
        w_min_rg     = (i_red <= i_green) ? i_red : i_green;
        w_min        = (w_min_rg <= i_blue) ? w_min_rg : i_blue;
        n_item.delta = n_item.vmax - w_min;
    end

    // Advance the stage flag: load on transfer, drop when pushed
    always_comb begin
        if (w_accept) begin
            n_valid = 1'b1;
        end else if (o_push) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= n_item;
        end
    end

endmodule

@@ rtl/rgbhsv_queue.sv @@
// Short FIFO between front and back of the RGB to HSV converter.
// The back drains one entry per cycle whenever the queue is not empty.
// Depends on rgbhsv_pkg.
module rgbhsv_queue #(
    parameter int DEPTH = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  rgbhsv_pkg::t_cls    i_item,
    output rgbhsv_pkg::t_q_stat o_stat,
    output logic                o_pop,
    output rgbhsv_pkg::t_cls    o_item
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    rgbhsv_pkg::t_cls r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [CNT_W-1:0] n_count;

    assign o_stat.full  = (r_count == CNT_W'(DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign o_pop        = !o_stat.empty;
    assign o_item       = r_mem[r_rd_ptr];

    // Advance pointers with wrap at the last entry
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (o_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        unique case ({i_push, o_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store the pushed entry
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

@@ rtl/rgbhsv_back.sv @@
// Back end of the RGB to HSV converter: forms the hue numerator and the
// saturation dividend, then runs two pipelined restoring dividers.
// Depends on rgbhsv_pkg.
module rgbhsv_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  rgbhsv_pkg::t_cls             i_item,
    output logic                         o_valid,
    output logic [rgbhsv_pkg::HUE_W-1:0] o_hue,
    output logic [rgbhsv_pkg::CH_W-1:0]  o_sat,
    output logic [rgbhsv_pkg::CH_W-1:0]  o_val
);

    localparam int CW = rgbhsv_pkg::CH_W;
    localparam int NW = rgbhsv_pkg::NUM_W;
    localparam int HW = rgbhsv_pkg::HUE_W;
    localparam int NS = rgbhsv_pkg::HUE_STEPS;
    localparam int SS = rgbhsv_pkg::SAT_STEPS;

    // Stage registers, index 0 is the setup stage
    logic [NS:0]   r_vld;
    logic [NW-1:0] r_hrem [NS+1];
    logic [NW-1:0] r_hdiv [NS+1];
    logic [HW-1:0] r_hq   [NS+1];
    logic [CW-1:0] r_srem [NS+1];
    logic [CW-1:0] r_slo  [NS+1];
    logic [CW-1:0] r_sq   [NS+1];
    logic [CW-1:0] r_sdiv [NS+1];
    logic [NS:0]   r_gray;
    logic [CW-1:0] r_val  [NS+1];

    logic          r_out_valid;
    logic [HW-1:0] r_out_hue;
    logic [CW-1:0] r_out_sat;
    logic [CW-1:0] r_out_val;

    // Setup signals
    logic [NW:0]     w_d;
    logic [NW:0]     w_sixd;
    logic [NW:0]     w_num_raw;
    logic [NW:0]     w_num;
    logic [2*CW-1:0] w_sat_n;

    // Build hue numerator (two's complement, wrapped by 6*delta)
    always_comb begin
        w_d    = (NW+1)'(i_item.delta);
        w_sixd = (w_d << 2) + (w_d << 1);
        unique case (i_item.sel)
            rgbhsv_pkg::SEL_RED:
                w_num_raw = (NW+1)'(i_item.green) - (NW+1)'(i_item.blue);
            rgbhsv_pkg::SEL_GREEN:
                w_num_raw = (w_d << 1) + (NW+1)'(i_item.blue) - (NW+1)'(i_item.red);
            rgbhsv_pkg::SEL_BLUE:
                w_num_raw = (w_d << 2) + (NW+1)'(i_item.red) - (NW+1)'(i_item.green);
            default:
                w_num_raw = '0;
        endcase
        w_num   = w_num_raw[NW] ? w_num_raw + w_sixd : w_num_raw;
        // delta*255 as (delta << 8) - delta
        w_sat_n = {i_item.delta, {CW{1'b0}}} - (2*CW)'(i_item.delta);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= i_valid;
        end
    end

    // Load the setup stage
    always_ff @(posedge i_clk) begin
        r_hrem[0] <= w_num[NW-1:0];
        r_hdiv[0] <= w_sixd[NW-1:0];
        r_hq[0]   <= '0;
        r_srem[0] <= w_sat_n[2*CW-1:CW];
        r_slo[0]  <= w_sat_n[CW-1:0];
        r_sq[0]   <= '0;
        r_sdiv[0] <= i_item.vmax;
        r_gray[0] <= (i_item.delta == '0);
        r_val[0]  <= i_item.vmax;
    end

    // One quotient bit of the hue divider per stage, and of the saturation divider in the first SAT_STEPS stages
    for (genvar k = 0; k < NS; k++) begin : g_stage
        logic [NW:0]   w_hrem2;
        logic          w_hge;
        logic [NW-1:0] n_hrem;
        logic [HW-1:0] n_hq;
        logic [CW-1:0] n_srem;
        logic [CW-1:0] n_slo;
        logic [CW-1:0] n_sq;

        assign w_hrem2 = {r_hrem[k], 1'b0};
        assign w_hge   = (w_hrem2 >= {1'b0, r_hdiv[k]});
        assign n_hrem  = w_hge ? NW'(w_hrem2 - {1'b0, r_hdiv[k]}) : w_hrem2[NW-1:0];
        assign n_hq    = {r_hq[k][HW-2:0], w_hge};

        if (k < SS) begin : g_sat
            logic [CW:0] w_srem2;
            logic        w_sge;
            assign w_srem2 = {r_srem[k], r_slo[k][CW-1]};
            assign w_sge   = (w_srem2 >= {1'b0, r_sdiv[k]});
            assign n_srem  = w_sge ? CW'(w_srem2 - {1'b0, r_sdiv[k]}) : w_srem2[CW-1:0];
            assign n_slo   = {r_slo[k][CW-2:0], 1'b0};
            assign n_sq    = {r_sq[k][CW-2:0], w_sge};
        end else begin : g_sat_done
            assign n_srem = r_srem[k];
            assign n_slo  = r_slo[k];
            assign n_sq   = r_sq[k];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else begin
                r_vld[k+1] <= r_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            r_hrem[k+1] <= n_hrem;
            r_hdiv[k+1] <= r_hdiv[k];
            r_hq[k+1]   <= n_hq;
            r_srem[k+1] <= n_srem;
            r_slo[k+1]  <= n_slo;
            r_sq[k+1]   <= n_sq;
            r_sdiv[k+1] <= r_sdiv[k];
            r_gray[k+1] <= r_gray[k];
            r_val[k+1]  <= r_val[k];
        end
    end

    // Output register; grey and black pixels give zero hue and saturation
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_vld[NS];
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_hue <= r_gray[NS] ? '0 : r_hq[NS];
        r_out_sat <= r_gray[NS] ? '0 : r_sq[NS];
        r_out_val <= r_val[NS];
    end

    assign o_valid = r_out_valid;
    assign o_hue   = r_out_hue;
    assign o_sat   = r_out_sat;
    assign o_val   = r_out_val;

endmodule

@@ rtl/rgb_to_hsv_converter_core.sv @@
// RGB to HSV converter, top level.
// Uses rgbhsv_pkg, rgbhsv_front, rgbhsv_queue and rgbhsv_back.
//
// Usage:
//   Drive i_red_in, i_green_in, i_blue_in and raise start. A pixel transfers
//   at a rising edge where start is high and busy is low.
//   Each result appears on o_hue_out, o_saturation_out and o_value_out for
//   exactly one cycle, marked by o_result_valid; the receiver must take it
//   then, there is no backpressure on the result side.
// Throughput: one pixel per clock. The back end is a 16-stage divider
//   pipeline (one hue quotient bit per stage, saturation in the first 8)
//   that takes a new entry every cycle, so the queue never fills and busy
//   stays low in normal operation.
// Path: a pixel passes through the front register, the queue, the setup stage,
//   16 divider stages and the output register before its result appears.
// Reset (i_rst_n low, synchronous): empties the queue and clears all valid
//   flags; pixels in flight are dropped and no result is issued.
// Hue is a fraction of a turn times 65536; saturation is delta*255/max
//   floored; value is the largest channel.
module rgb_to_hsv_converter_core #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [rgbhsv_pkg::CH_W-1:0]  i_red_in,
    input  logic [rgbhsv_pkg::CH_W-1:0]  i_green_in,
    input  logic [rgbhsv_pkg::CH_W-1:0]  i_blue_in,
    output logic                         o_result_valid,
    output logic [rgbhsv_pkg::HUE_W-1:0] o_hue_out,
    output logic [rgbhsv_pkg::CH_W-1:0]  o_saturation_out,
    output logic [rgbhsv_pkg::CH_W-1:0]  o_value_out
);

    rgbhsv_pkg::t_q_stat w_q_stat;
    rgbhsv_pkg::t_cls    w_front_item;
    rgbhsv_pkg::t_cls    w_back_item;
    logic                w_push;
    logic                w_pop;

    // Accept and classify pixels
    rgbhsv_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_red    (i_red_in),
        .i_green  (i_green_in),
        .i_blue   (i_blue_in),
        .i_q_stat (w_q_stat),
        .o_busy   (busy),
        .o_push   (w_push),
        .o_item   (w_front_item)
    );

    // Decouple front and back
    rgbhsv_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_front_item),
        .o_stat  (w_q_stat),
        .o_pop   (w_pop),
        .o_item  (w_back_item)
    );

    // Compute hue and saturation
    rgbhsv_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_pop),
        .i_item  (w_back_item),
        .o_valid (o_result_valid),
        .o_hue   (o_hue_out),
        .o_sat   (o_saturation_out),
        .o_val   (o_value_out)
    );

    // The back drains every cycle, so the queue never backs up
    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy)
        else $error("queue backed up into the front");

    // Zero saturation only for grey pixels, which carry zero hue
    a_grey_hue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && (o_saturation_out == '0) |-> (o_hue_out == '0))
        else $error("grey pixel with nonzero hue");

    // Nonzero saturation needs a nonzero maximum
    a_sat_val: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && (o_saturation_out != '0) |-> (o_value_out != '0))
        else $error("saturation without value");

    // No result right after a reset cycle
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_result_valid)
        else $error("result issued after reset");

endmodule
